/* sv/gpio_pkg.sv */
`timescale 1ns / 1ps

package gpio_pkg;

   // number of controller ports and register widths
   localparam int unsigned NumPorts  = 3;
   localparam int unsigned ByteWidth = 8;
   localparam int unsigned OffWidth  = 5;

   // configuration port
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;

   // reset value of the version register
   localparam logic [ByteWidth-1:0] VersionReset = 8'ha0;

   // pad line positions
   localparam int unsigned ThBit = 6;

   // register group selected by offset bits 4:1
   typedef enum logic [OffWidth-2:0] {
      SEL_VERSION = 4'd0,
      SEL_DATA0   = 4'd1,
      SEL_DATA1   = 4'd2,
      SEL_DATA2   = 4'd3,
      SEL_DIR0    = 4'd4,
      SEL_DIR1    = 4'd5,
      SEL_DIR2    = 4'd6
   } reg_sel_type;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_VERSION = 1'b0
   } csr_index_type;

   // bus access kinds
   localparam logic FuncRead  = 1'b0;
   localparam logic FuncWrite = 1'b1;

endpackage

/* sv/gpio_port_mux.sv */
`timescale 1ns / 1ps

module gpio_port_mux (
   input  logic [gpio_pkg::ByteWidth-1:0] port_data,
   input  logic [gpio_pkg::ByteWidth-1:0] port_dir,
   input  logic [gpio_pkg::ByteWidth-1:0] buttons,
   output logic [gpio_pkg::ByteWidth-1:0] port_value
);

   logic [gpio_pkg::ByteWidth-1:0] drv;
   logic [gpio_pkg::ByteWidth-1:0] nb;
   logic [gpio_pkg::ByteWidth-1:0] pad_in;
   logic                           th_high;

   // output bits come from the data register
   assign drv = port_data & port_dir;

   // th pulls high unless it is driven low
   assign th_high = !port_dir[gpio_pkg::ThBit] || drv[gpio_pkg::ThBit];

   // active-low pad lines, group chosen by th
   assign nb = ~buttons;
   always_comb begin
      if (th_high) begin
         pad_in = {1'b0, 1'b1, nb[5:0]};
      end else begin
         pad_in = {2'b00, nb[7], nb[6], 2'b00, nb[1:0]};
      end
   end

   // merge driven bits with pad inputs
   assign port_value = drv | (pad_in & ~port_dir);

endmodule

/* sv/gamepad_io_port_controller.sv */
`timescale 1ns / 1ps

// channel  | ports                                   | direction
// ---------+-----------------------------------------+----------
// request  | req_valid/ready, func, reg_offset, ...  | in
// response | rsp_valid/ready, rsp_read_data          | out
// csr      | csr_psel/penable/pwrite/paddr/pwdata    | in/out
//
// a request passes one request register, then the decode, port mux and
// register update, then the response register that drives rsp_valid.
// one access is taken every cycle while the response side keeps up.
// synchronous reset clears the port data and direction registers, sets the
// version to 0xa0 and empties both stages; a stalled response holds the
// request stage, which still takes one more transfer before req_ready drops.

module gamepad_io_port_controller (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_func,
   input  logic [gpio_pkg::OffWidth-1:0]     req_reg_offset,
   input  logic [gpio_pkg::ByteWidth-1:0]    req_write_data,
   input  logic [gpio_pkg::ByteWidth-1:0]    req_buttons_a,
   input  logic [gpio_pkg::ByteWidth-1:0]    req_buttons_b,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [gpio_pkg::ByteWidth-1:0]    rsp_read_data,
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gpio_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [gpio_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [gpio_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                              csr_pready
);

   localparam int unsigned BW = gpio_pkg::ByteWidth;

   // request stage
   logic                           req_valid_ff;
   logic                           func_ff;
   logic [gpio_pkg::OffWidth-1:0]  off_ff;
   logic [BW-1:0]                  wdata_ff;
   logic [BW-1:0]                  btn_a_ff;
   logic [BW-1:0]                  btn_b_ff;

   // response stage
   logic                           rsp_valid_ff;
   logic [BW-1:0]                  rsp_data_ff;
   logic [BW-1:0]                  rsp_data_in;

   // block state
   logic [BW-1:0]                  version_ff;
   logic [BW-1:0]                  data_ff [gpio_pkg::NumPorts];
   logic [BW-1:0]                  dir_ff  [gpio_pkg::NumPorts];

   logic                           stage_go;
   logic                           csr_write;
   gpio_pkg::reg_sel_type          sel;
   logic [BW-1:0]                  port_value [gpio_pkg::NumPorts];
   logic [BW-1:0]                  no_buttons;

   // handshakes
   assign stage_go  = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || stage_go;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         func_ff  <= req_func;
         off_ff   <= req_reg_offset;
         wdata_ff <= req_write_data;
         btn_a_ff <= req_buttons_a;
         btn_b_ff <= req_buttons_b;
      end
   end

   // port read muxes, port 2 has no pad
   assign no_buttons = '0;

   gpio_port_mux u_port0 (
      .port_data  (data_ff[0]),
      .port_dir   (dir_ff[0]),
      .buttons    (btn_a_ff),
      .port_value (port_value[0])
   );

   gpio_port_mux u_port1 (
      .port_data  (data_ff[1]),
      .port_dir   (dir_ff[1]),
      .buttons    (btn_b_ff),
      .port_value (port_value[1])
   );

   gpio_port_mux u_port2 (
      .port_data  (data_ff[2]),
      .port_dir   (dir_ff[2]),
      .buttons    (no_buttons),
      .port_value (port_value[2])
   );

   // read decode
   assign sel = gpio_pkg::reg_sel_type'(off_ff[gpio_pkg::OffWidth-1:1]);

   always_comb begin
      rsp_data_in = '0;
      if (func_ff == gpio_pkg::FuncRead) begin
         unique case (sel)
            gpio_pkg::SEL_VERSION: rsp_data_in = version_ff;
            gpio_pkg::SEL_DATA0:   rsp_data_in = port_value[0];
            gpio_pkg::SEL_DATA1:   rsp_data_in = port_value[1];
            gpio_pkg::SEL_DATA2:   rsp_data_in = port_value[2];
            gpio_pkg::SEL_DIR0:    rsp_data_in = dir_ff[0];
            gpio_pkg::SEL_DIR1:    rsp_data_in = dir_ff[1];
            gpio_pkg::SEL_DIR2:    rsp_data_in = dir_ff[2];
            default:               rsp_data_in = '0;
         endcase
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stage_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (stage_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // port register writes at odd offsets
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < gpio_pkg::NumPorts; i++) begin
            data_ff[i] <= '0;
            dir_ff[i]  <= '0;
         end
      end else if (stage_go && func_ff == gpio_pkg::FuncWrite && off_ff[0]) begin
         unique case (sel)
            gpio_pkg::SEL_DATA0: data_ff[0] <= wdata_ff;
            gpio_pkg::SEL_DATA1: data_ff[1] <= wdata_ff;
            gpio_pkg::SEL_DATA2: data_ff[2] <= wdata_ff;
            gpio_pkg::SEL_DIR0:  dir_ff[0]  <= wdata_ff;
            gpio_pkg::SEL_DIR1:  dir_ff[1]  <= wdata_ff;
            gpio_pkg::SEL_DIR2:  dir_ff[2]  <= wdata_ff;
            default: ;
         endcase
      end
   end

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= gpio_pkg::VersionReset;
      end else if (csr_write &&
                   csr_paddr[gpio_pkg::CsrAddrWidth-1] == gpio_pkg::CSR_VERSION) begin
         version_ff <= csr_pwdata[BW-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[gpio_pkg::CsrAddrWidth-1] == gpio_pkg::CSR_VERSION) begin
         csr_prdata = {{(gpio_pkg::CsrDataWidth-BW){1'b0}}, version_ff};
      end
   end

`ifndef ASSERT_OFF
   // a write transfer always answers with zero
   a_write_reads_zero: assert property (@(posedge clock) disable iff (reset)
      stage_go && func_ff == gpio_pkg::FuncWrite |=> rsp_valid_ff && rsp_data_ff == '0)
      else $error("write transfer did not return zero");

   // a port 0 data write lands in the data register
   a_data0_write: assert property (@(posedge clock) disable iff (reset)
      stage_go && func_ff == gpio_pkg::FuncWrite && off_ff[0] &&
      sel == gpio_pkg::SEL_DATA0 |=> data_ff[0] == $past(wdata_ff))
      else $error("port 0 data write lost");

   // a direction register read returns the stored value
   a_dir0_read: assert property (@(posedge clock) disable iff (reset)
      stage_go && func_ff == gpio_pkg::FuncRead && sel == gpio_pkg::SEL_DIR0
      |=> rsp_data_ff == $past(dir_ff[0]))
      else $error("port 0 direction read mismatch");

   // a stalled response keeps the request stage from advancing
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !stage_go)
      else $error("response overwritten while stalled");
`endif

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;

   // unused configuration slot, writes there must not reach the version register
   localparam logic [gpio_pkg::CsrAddrWidth-1:0] VersionAddr =
      gpio_pkg::CsrAddrWidth'(4 * gpio_pkg::CSR_VERSION);
   localparam logic [gpio_pkg::CsrAddrWidth-1:0] UnusedCsrAddr =
      gpio_pkg::CsrAddrWidth'(4 * (gpio_pkg::CSR_VERSION + 1));
   localparam int unsigned PipeLatency = 4;
   localparam int unsigned PhaseItems  = 175;

   typedef struct {
      logic                           func;
      logic [gpio_pkg::OffWidth-1:0]  reg_offset;
      logic [gpio_pkg::ByteWidth-1:0] read_data;
   } access_result_type;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic                              req_func;
   logic [gpio_pkg::OffWidth-1:0]     req_reg_offset;
   logic [gpio_pkg::ByteWidth-1:0]    req_write_data;
   logic [gpio_pkg::ByteWidth-1:0]    req_buttons_a;
   logic [gpio_pkg::ByteWidth-1:0]    req_buttons_b;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic [gpio_pkg::ByteWidth-1:0]    rsp_read_data;
   logic                              csr_psel;
   logic                              csr_penable;
   logic                              csr_pwrite;
   logic [gpio_pkg::CsrAddrWidth-1:0] csr_paddr;
   logic [gpio_pkg::CsrDataWidth-1:0] csr_pwdata;
   logic [gpio_pkg::CsrDataWidth-1:0] csr_prdata;
   logic                              csr_pready;

   // shadow copy of the block state
   logic [gpio_pkg::ByteWidth-1:0] version_shadow;
   logic [gpio_pkg::ByteWidth-1:0] port_data_shadow [gpio_pkg::NumPorts];
   logic [gpio_pkg::ByteWidth-1:0] port_dir_shadow [gpio_pkg::NumPorts];

   access_result_type read_data_expected [$];

   int unsigned send_idle_pct;
   int unsigned rsp_stall_pct;
   int unsigned error_count;
   int unsigned reads_sent;
   int unsigned writes_sent;
   int unsigned results_checked;
   int unsigned version_settings;

   gamepad_io_port_controller DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_reg_offset (req_reg_offset),
      .req_write_data (req_write_data),
      .req_buttons_a  (req_buttons_a),
      .req_buttons_b  (req_buttons_b),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // pad value seen on one port, mixed with the driven bits
   function automatic logic [gpio_pkg::ByteWidth-1:0] pad_port_read(
         int unsigned port, logic [gpio_pkg::ByteWidth-1:0] buttons);
      logic [gpio_pkg::ByteWidth-1:0] dir;
      logic [gpio_pkg::ByteWidth-1:0] driven;
      logic [gpio_pkg::ByteWidth-1:0] pad_in;
      logic                           th_high;
      dir     = port_dir_shadow[port];
      driven  = port_data_shadow[port] & dir;
      th_high = !dir[gpio_pkg::ThBit] || driven[gpio_pkg::ThBit];
      if (th_high) begin
         pad_in = {2'b01, ~buttons[5:0]};
      end else begin
         pad_in = {2'b00, ~buttons[7], ~buttons[6], 2'b00, ~buttons[1:0]};
      end
      return driven | (pad_in & ~dir);
   endfunction

   // expected read data of one access, updates the shadow registers on writes
   function automatic logic [gpio_pkg::ByteWidth-1:0] predict_access(
         logic func, logic [gpio_pkg::OffWidth-1:0] off,
         logic [gpio_pkg::ByteWidth-1:0] wdata,
         logic [gpio_pkg::ByteWidth-1:0] btn_a,
         logic [gpio_pkg::ByteWidth-1:0] btn_b);
      gpio_pkg::reg_sel_type sel;
      sel = gpio_pkg::reg_sel_type'(off[gpio_pkg::OffWidth-1:1]);
      if (func == gpio_pkg::FuncWrite) begin
         if (off[0]) begin
            case (sel)
               gpio_pkg::SEL_DATA0: port_data_shadow[0] = wdata;
               gpio_pkg::SEL_DATA1: port_data_shadow[1] = wdata;
               gpio_pkg::SEL_DATA2: port_data_shadow[2] = wdata;
               gpio_pkg::SEL_DIR0:  port_dir_shadow[0]  = wdata;
               gpio_pkg::SEL_DIR1:  port_dir_shadow[1]  = wdata;
               gpio_pkg::SEL_DIR2:  port_dir_shadow[2]  = wdata;
               default: ;
            endcase
         end
         return '0;
      end
      case (sel)
         gpio_pkg::SEL_VERSION: return version_shadow;
         gpio_pkg::SEL_DATA0:   return pad_port_read(0, btn_a);
         gpio_pkg::SEL_DATA1:   return pad_port_read(1, btn_b);
         gpio_pkg::SEL_DATA2:   return pad_port_read(2, '0);
         gpio_pkg::SEL_DIR0:    return port_dir_shadow[0];
         gpio_pkg::SEL_DIR1:    return port_dir_shadow[1];
         gpio_pkg::SEL_DIR2:    return port_dir_shadow[2];
         default:               return '0;
      endcase
   endfunction

   // one bus access on the request channel
   task automatic send_access(logic func, logic [gpio_pkg::OffWidth-1:0] off,
                              logic [gpio_pkg::ByteWidth-1:0] wdata,
                              logic [gpio_pkg::ByteWidth-1:0] btn_a,
                              logic [gpio_pkg::ByteWidth-1:0] btn_b);
      access_result_type entry;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_reg_offset <= off;
      req_write_data <= wdata;
      req_buttons_a  <= btn_a;
      req_buttons_b  <= btn_b;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      entry.func       = func;
      entry.reg_offset = off;
      entry.read_data  = predict_access(func, off, wdata, btn_a, btn_b);
      read_data_expected.push_back(entry);
      if (func == gpio_pkg::FuncWrite) writes_sent++;
      else reads_sent++;
   endtask

   // random access, mostly aimed at the mapped registers
   task automatic send_random_access();
      logic                           func;
      logic [gpio_pkg::OffWidth-1:0]  off;
      logic [gpio_pkg::ByteWidth-1:0] btn_a;
      logic [gpio_pkg::ByteWidth-1:0] btn_b;
      func = 1'($urandom_range(1));
      if ($urandom_range(9) == 0) begin
         off = gpio_pkg::OffWidth'($urandom_range(31));
      end else if (func == gpio_pkg::FuncWrite && $urandom_range(3) != 0) begin
         off = gpio_pkg::OffWidth'(2 * $urandom_range(6, 1) + 1);
      end else begin
         off = gpio_pkg::OffWidth'($urandom_range(13));
      end
      btn_a = gpio_pkg::ByteWidth'($urandom_range(255));
      btn_b = gpio_pkg::ByteWidth'($urandom_range(255));
      // now and then nothing or everything pressed
      case ($urandom_range(7))
         0: btn_a = '0;
         1: btn_a = '1;
         2: btn_b = '0;
         3: btn_b = '1;
         default: ;
      endcase
      send_access(func, off, gpio_pkg::ByteWidth'($urandom_range(255)), btn_a, btn_b);
   endtask

   // drop valid and wait until every response is back
   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (read_data_expected.size() != 0) @(posedge clock);
      repeat (PipeLatency) @(posedge clock);
   endtask

   // csr write, read back when the address holds the version register
   task automatic csr_write(logic [gpio_pkg::CsrAddrWidth-1:0] addr,
                            logic [gpio_pkg::ByteWidth-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= gpio_pkg::CsrDataWidth'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      forever begin
         @(posedge clock);
         if (csr_pready) break;
      end
      if (addr == VersionAddr) begin
         version_shadow = value;
         version_settings++;
         @(negedge clock);
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b0;
         @(negedge clock);
         csr_penable <= 1'b1;
         forever begin
            @(posedge clock);
            if (csr_pready) break;
         end
         if (csr_prdata[gpio_pkg::ByteWidth-1:0] !== version_shadow) begin
            $display("%0t csr version readback: expected %02h actual %02h",
                     $time, version_shadow, csr_prdata[gpio_pkg::ByteWidth-1:0]);
            error_count++;
         end
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // response checker
   always @(posedge clock) begin
      access_result_type exp_entry;
      if (!reset && rsp_valid && rsp_ready) begin
         if (read_data_expected.size() == 0) begin
            $display("%0t unexpected response: expected none actual %02h",
                     $time, rsp_read_data);
            error_count++;
         end else begin
            exp_entry = read_data_expected.pop_front();
            results_checked++;
            if (rsp_read_data !== exp_entry.read_data) begin
               $display("%0t read_data mismatch (func %0d offset %02h): %s %02h %s %02h",
                        $time, exp_entry.func, exp_entry.reg_offset,
                        "expected", exp_entry.read_data, "actual", rsp_read_data);
               error_count++;
            end
         end
      end
   end

   // response side stalls
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // reset values, every register group, pad th selection and ignored accesses
   task automatic test_directed();
      send_access(gpio_pkg::FuncRead, 5'h00, 8'h00, 8'h00, 8'h00);
      send_access(gpio_pkg::FuncRead, 5'h01, 8'hff, 8'hff, 8'hff);
      // th as input reads high: c,b,r,l,d,u group
      send_access(gpio_pkg::FuncRead, 5'h02, 8'h00, 8'hff, 8'h00);
      send_access(gpio_pkg::FuncRead, 5'h03, 8'h00, 8'h00, 8'hff);
      send_access(gpio_pkg::FuncRead, 5'h04, 8'h00, 8'h00, 8'h2a);
      send_access(gpio_pkg::FuncRead, 5'h07, 8'h00, 8'hff, 8'hff);
      // th driven low: start,a,d,u group
      send_access(gpio_pkg::FuncWrite, 5'h09, 8'h40, 8'h00, 8'h00);
      send_access(gpio_pkg::FuncWrite, 5'h03, 8'h00, 8'h00, 8'h00);
      send_access(gpio_pkg::FuncRead, 5'h02, 8'h00, 8'h80, 8'h00);
      send_access(gpio_pkg::FuncRead, 5'h03, 8'h00, 8'h41, 8'h00);
      // th driven high
      send_access(gpio_pkg::FuncWrite, 5'h03, 8'hff, 8'h00, 8'h00);
      send_access(gpio_pkg::FuncRead, 5'h02, 8'h00, 8'h3c, 8'h00);
      // even and unmapped write offsets are ignored
      send_access(gpio_pkg::FuncWrite, 5'h08, 8'hff, 8'h00, 8'h00);
      send_access(gpio_pkg::FuncWrite, 5'h1f, 8'hff, 8'h00, 8'h00);
      send_access(gpio_pkg::FuncRead, 5'h08, 8'h00, 8'h00, 8'h00);
      // unmapped reads
      send_access(gpio_pkg::FuncRead, 5'h0e, 8'h00, 8'hff, 8'hff);
      send_access(gpio_pkg::FuncRead, 5'h1f, 8'h00, 8'hff, 8'hff);
      // port without a pad, all outputs
      send_access(gpio_pkg::FuncWrite, 5'h0d, 8'hff, 8'h00, 8'h00);
      send_access(gpio_pkg::FuncWrite, 5'h07, 8'ha5, 8'h00, 8'h00);
      send_access(gpio_pkg::FuncRead, 5'h06, 8'h00, 8'h00, 8'h00);
      send_access(gpio_pkg::FuncRead, 5'h0c, 8'h00, 8'h00, 8'h00);
      // second pad with mixed direction
      send_access(gpio_pkg::FuncWrite, 5'h0b, 8'h0f, 8'h00, 8'h00);
      send_access(gpio_pkg::FuncWrite, 5'h05, 8'hf0, 8'h00, 8'h00);
      send_access(gpio_pkg::FuncRead, 5'h04, 8'h00, 8'h00, 8'h5a);
      send_access(gpio_pkg::FuncRead, 5'h0a, 8'h00, 8'h00, 8'h00);
      drain_responses();
   endtask

   // version register extremes and a write to an unused slot
   task automatic test_version_register();
      csr_write(VersionAddr, 8'h00);
      send_access(gpio_pkg::FuncRead, 5'h00, 8'h00, 8'h00, 8'h00);
      drain_responses();
      csr_write(VersionAddr, 8'hff);
      send_access(gpio_pkg::FuncRead, 5'h01, 8'h00, 8'h00, 8'h00);
      drain_responses();
      csr_write(UnusedCsrAddr, 8'h12);
      send_access(gpio_pkg::FuncRead, 5'h00, 8'h00, 8'h00, 8'h00);
      drain_responses();
   endtask

   // random traffic under each idling pattern, new version value per phase
   task automatic test_random_traffic();
      int unsigned idle_pct [4];
      int unsigned stall_pct [4];
      idle_pct  = '{0, 55, 0, 35};
      stall_pct = '{0, 0, 55, 35};
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       csr_write(VersionAddr, 8'h00);
            1:       csr_write(VersionAddr, 8'hff);
            default: csr_write(VersionAddr, gpio_pkg::ByteWidth'($urandom_range(255)));
         endcase
         send_idle_pct = idle_pct[phase];
         rsp_stall_pct = stall_pct[phase];
         for (int n = 0; n < PhaseItems; n++) send_random_access();
         drain_responses();
      end
   endtask

   // sender holds off until the backlog is gone, then resumes
   task automatic test_pause_until_drained();
      send_idle_pct = 0;
      rsp_stall_pct = 55;
      for (int n = 0; n < 15; n++) send_random_access();
      @(negedge clock);
      req_valid <= 1'b0;
      while (read_data_expected.size() != 0) @(posedge clock);
      for (int n = 0; n < 15; n++) send_random_access();
      drain_responses();
      rsp_stall_pct = 0;
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_func         = gpio_pkg::FuncRead;
      req_reg_offset   = '0;
      req_write_data   = '0;
      req_buttons_a    = '0;
      req_buttons_b    = '0;
      rsp_ready        = 1'b1;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      send_idle_pct    = 0;
      rsp_stall_pct    = 0;
      error_count      = 0;
      reads_sent       = 0;
      writes_sent      = 0;
      results_checked  = 0;
      version_settings = 0;
      version_shadow   = gpio_pkg::VersionReset;
      for (int p = 0; p < gpio_pkg::NumPorts; p++) begin
         port_data_shadow[p] = '0;
         port_dir_shadow[p]  = '0;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_version_register();
      test_random_traffic();
      test_pause_until_drained();

      $display("covered %0d reads and %0d writes, %0d responses checked",
               reads_sent, writes_sent, results_checked);
      $display("%0d version settings, four idling patterns and one full drain pause",
               version_settings);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/gpio_pkg.sv
sv/gpio_port_mux.sv
sv/gamepad_io_port_controller.sv
test/tb.sv
